// File: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FCSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FCSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fcsu_pkg.sv
package fcsu_pkg;

    localparam int unsigned MaxSymbols = 127;

    localparam logic [7:0] SYNC_FIRST   = 8'h2D;
    localparam logic [7:0] SYNC_SECOND  = 8'hD4;
    localparam logic [7:0] LEN_HIGH_BIT = 8'h80;
    localparam logic [5:0] SYMBOL_MASK  = 6'h3F;
    localparam logic [7:0] HEADER_BYTES = 8'd3;
    localparam logic [7:0] FRAME_MIN    = 8'd5;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_NO_SYNC  = 3'd2;
    localparam logic [2:0] ST_BIT7     = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_SIZE     = 3'd5;
    localparam logic [2:0] ST_CRC      = 3'd6;

    typedef struct packed {
        logic       kind;
        logic [5:0] sym;
        logic [2:0] status;
        logic [7:0] len;
        logic       last;
    } fcsu_result_t;

    typedef struct packed {
        logic [1:0]             count;
        fcsu_result_t [2:0]     res;
    } fcsu_group_t;

    // crc-16/ccitt-false, one byte msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // ceil(6*len/8)
    function automatic logic [7:0] packed_bytes(input logic [7:0] len);
        logic [10:0] t;
        t = {1'b0, len, 2'b00} + {2'b00, len, 1'b0} + 11'd7;
        return t[10:3];
    endfunction

    function automatic logic length_ok(input logic [7:0] len);
        return ((len & LEN_HIGH_BIT) == 8'd0) && ({24'd0, len} <= MaxSymbols);
    endfunction

endpackage

// File: rtl/fcsu_core.sv
module fcsu_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 go,
    input  logic [7:0]           frame_byte,
    input  logic                 end_of_frame,
    output fcsu_pkg::fcsu_group_t group_o
);

    logic [7:0]  bytes_reg, bytes_next;
    logic        sync_reg, sync_next;
    logic [7:0]  field_reg, field_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] trailer_reg, trailer_next;
    logic [4:0]  resv_reg, resv_next;
    logic [2:0]  fill_reg, fill_next;
    logic [6:0]  sent_reg, sent_next;

    logic [7:0]  len;
    logic        payload;
    logic [12:0] buf0, buf1, buf2;
    logic [3:0]  cnt0, cnt1, cnt2;
    logic [6:0]  sent1, sent2;
    logic        take0, take1;
    logic [5:0]  sym0, sym1;
    logic [1:0]  n_sym;
    logic [7:0]  seen;
    logic [2:0]  status;
    logic [1:0]  count;
    fcsu_pkg::fcsu_result_t [2:0] res;

    always_comb begin
        len = (bytes_reg == 8'd2) ? frame_byte : field_reg;

        sync_next = sync_reg;
        if (bytes_reg == 8'd0 && frame_byte != fcsu_pkg::SYNC_FIRST) begin
            sync_next = 1'b0;
        end
        if (bytes_reg == 8'd1 && frame_byte != fcsu_pkg::SYNC_SECOND) begin
            sync_next = 1'b0;
        end
        field_next = len;

        payload = (bytes_reg >= fcsu_pkg::HEADER_BYTES) && fcsu_pkg::length_ok(len)
                  && ({1'b0, bytes_reg} < ({1'b0, fcsu_pkg::HEADER_BYTES}
                                           + {1'b0, fcsu_pkg::packed_bytes(len)}));

        // unpack up to two symbols from reservoir plus new byte
        buf0  = {resv_reg, frame_byte};
        cnt0  = {1'b0, fill_reg} + 4'd8;
        take0 = payload && cnt0 >= 4'd6 && {1'b0, sent_reg} < len;
        cnt1  = take0 ? cnt0 - 4'd6 : cnt0;
        sym0  = 6'(buf0 >> cnt1) & fcsu_pkg::SYMBOL_MASK;
        buf1  = take0 ? (buf0 & ((13'd1 << cnt1) - 13'd1)) : buf0;
        sent1 = take0 ? sent_reg + 7'd1 : sent_reg;
        take1 = take0 && cnt1 >= 4'd6 && {1'b0, sent1} < len;
        cnt2  = take1 ? cnt1 - 4'd6 : cnt1;
        sym1  = 6'(buf1 >> cnt2) & fcsu_pkg::SYMBOL_MASK;
        buf2  = take1 ? (buf1 & ((13'd1 << cnt2) - 13'd1)) : buf1;
        sent2 = take1 ? sent1 + 7'd1 : sent1;
        n_sym = {1'b0, take0} + {1'b0, take1};

        crc_next  = payload ? fcsu_pkg::crc_byte(crc_reg, frame_byte) : crc_reg;
        resv_next = payload ? buf2[4:0] : resv_reg;
        fill_next = payload ? cnt2[2:0] : fill_reg;
        sent_next = sent2;

        trailer_next = {trailer_reg[7:0], frame_byte};
        bytes_next   = (bytes_reg == 8'hFF) ? bytes_reg : bytes_reg + 8'd1;

        // status in check order
        seen = (bytes_next > 8'd2) ? field_next : 8'd0;
        if (bytes_next < fcsu_pkg::FRAME_MIN) begin
            status = fcsu_pkg::ST_SHORT;
        end else if (!sync_next) begin
            status = fcsu_pkg::ST_NO_SYNC;
        end else if ((seen & fcsu_pkg::LEN_HIGH_BIT) != 8'd0) begin
            status = fcsu_pkg::ST_BIT7;
        end else if ({24'd0, seen} > fcsu_pkg::MaxSymbols) begin
            status = fcsu_pkg::ST_TOO_LONG;
        end else if ({1'b0, bytes_next} != ({1'b0, fcsu_pkg::FRAME_MIN}
                                           + {1'b0, fcsu_pkg::packed_bytes(seen)})) begin
            status = fcsu_pkg::ST_SIZE;
        end else if (trailer_next != crc_next) begin
            status = fcsu_pkg::ST_CRC;
        end else begin
            status = fcsu_pkg::ST_OK;
        end

        res = '0;
        if (take0) begin
            res[0].kind = fcsu_pkg::KIND_SYMBOL;
            res[0].sym  = sym0;
            res[0].len  = len;
        end
        if (take1) begin
            res[1].kind = fcsu_pkg::KIND_SYMBOL;
            res[1].sym  = sym1;
            res[1].len  = len;
        end
        count = n_sym + {1'b0, end_of_frame};
        if (end_of_frame) begin
            res[n_sym].kind   = fcsu_pkg::KIND_STATUS;
            res[n_sym].status = status;
            res[n_sym].len    = seen;
        end
        if (count != 2'd0) begin
            res[count - 2'd1].last = 1'b1;
        end
        group_o.count = count;
        group_o.res   = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg   <= 8'd0;
            sync_reg    <= 1'b1;
            field_reg   <= 8'd0;
            crc_reg     <= fcsu_pkg::CRC_INIT;
            trailer_reg <= 16'd0;
            resv_reg    <= 5'd0;
            fill_reg    <= 3'd0;
            sent_reg    <= 7'd0;
        end else if (go) begin
            if (end_of_frame) begin
                bytes_reg   <= 8'd0;
                sync_reg    <= 1'b1;
                field_reg   <= 8'd0;
                crc_reg     <= fcsu_pkg::CRC_INIT;
                trailer_reg <= 16'd0;
                resv_reg    <= 5'd0;
                fill_reg    <= 3'd0;
                sent_reg    <= 7'd0;
            end else begin
                bytes_reg   <= bytes_next;
                sync_reg    <= sync_next;
                field_reg   <= field_next;
                crc_reg     <= crc_next;
                trailer_reg <= trailer_next;
                resv_reg    <= resv_next;
                fill_reg    <= fill_next;
                sent_reg    <= sent_next;
            end
        end
    end

endmodule

// File: rtl/frame_checker_symbol_unpacker_top.sv
// channel  | direction | tdata                          | tuser     | tlast
// s_       | in        | [7:0] frame_byte               | -         | end_of_frame
// m_       | out       | [5:0] sym [8:6] st [16:9] len  | item_kind | last_of_run
//
// one input word is taken per cycle as long as each word yields at most one result and m_ does not stall
// a word that yields two or three results (symbols and/or status) holds the result
// register until all of them are sent, since the m_ side moves one word per cycle
// an input register in front of the core holds the next word while results drain
// reset (aresetn low, synchronous) clears the valid flags of both registers and the frame state
// stalls on m_ propagate back to s_tready once the input register is occupied
`include "assert_macros.svh"

module frame_checker_symbol_unpacker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // end_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] payload_symbol, [8:6] frame_status,
                                   // [16:9] length_seen, [23:17] zero
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // last_of_run
);

    // input word register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;

    // result group register, drained one word per cycle while m_tready is high
    fcsu_pkg::fcsu_group_t grp_reg;
    logic                  grp_valid_reg;
    logic [1:0]            rd_ptr_reg;

    fcsu_pkg::fcsu_group_t core_grp;
    fcsu_pkg::fcsu_result_t cur;
    logic out_take;
    logic grp_done;
    logic core_go;
    logic load;

    assign out_take = grp_valid_reg && m_tready;
    assign grp_done = out_take && (rd_ptr_reg == grp_reg.count - 2'd1);
    // the core consumes the held word once the result register is free or its last word is taken
    assign core_go  = in_valid_reg && (!grp_valid_reg || grp_done);
    assign load     = core_go && (core_grp.count != 2'd0);
    assign s_tready = !in_valid_reg || core_go;

    fcsu_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .go           (core_go),
        .frame_byte   (in_byte_reg),
        .end_of_frame (in_eof_reg),
        .group_o      (core_grp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (core_go) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            rd_ptr_reg    <= 2'd0;
        end else if (load) begin
            grp_valid_reg <= 1'b1;
            rd_ptr_reg    <= 2'd0;
        end else if (grp_done) begin
            grp_valid_reg <= 1'b0;
            rd_ptr_reg    <= 2'd0;
        end else if (out_take) begin
            rd_ptr_reg    <= rd_ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= core_grp;
        end
    end

    // current output word
    assign cur      = grp_reg.res[rd_ptr_reg];
    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = {7'd0, cur.len, cur.status, cur.sym};
    assign m_tuser  = cur.kind;
    assign m_tlast  = cur.last;

    // read pointer never passes the group's result count
    `FCSU_ASSERT_NOW(a_ptr_in_group, aclk, aresetn, grp_valid_reg,
        rd_ptr_reg < grp_reg.count, "read pointer beyond result group")
    // a status word always closes the results of its input word
    `FCSU_ASSERT_NOW(a_status_last, aclk, aresetn, m_tvalid && m_tuser,
        m_tlast, "status word not marked last")
    // symbol words carry a zero status field
    `FCSU_ASSERT_NOW(a_symbol_status, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata[8:6] == fcsu_pkg::ST_OK, "symbol word with nonzero status")
    // a finished group with no waiting word is emptied on the next cycle
    `FCSU_ASSERT_NEXT(a_group_turnover, aclk, aresetn, grp_done && !in_valid_reg,
        !grp_valid_reg, "group still valid after final word")

endmodule
